FILE: rtl/pwm_pulse_train_generator_assert.svh
// ---------------------------------------------------------------------------
// PWM pulse train generator assertion macros
// Shared concurrent assertion forms for the generator's self checks.
// ---------------------------------------------------------------------------
`ifndef PWM_PULSE_TRAIN_GENERATOR_ASSERT_SVH
`define PWM_PULSE_TRAIN_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pwm_ptg_pkg.sv
// ---------------------------------------------------------------------------
// PWM pulse train generator package
// Payload types, command codes, run modes and register indexes.
// ---------------------------------------------------------------------------
package pwm_ptg_pkg;

   localparam int KIND_WIDTH      = 3;
   localparam int DUTY_WIDTH      = 7;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int DUTY_MAX        = 100;
   localparam int DUTY_DIVISOR    = 100;

   // Request kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_TICK      = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_START_PWM = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_START_PLS = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_ONE_SHOT  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_STOP      = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_SET_LEVEL = 3'd5;

   // Run modes.
   localparam logic [1:0] MODE_CONT  = 2'd0;
   localparam logic [1:0] MODE_PULSE = 2'd1;
   localparam logic [1:0] MODE_SHOT  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PERIOD   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DUTY     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PULSES   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ONE_SHOT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INVERT   = 3'd4;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic                  level;
   } req_type;

   typedef struct packed {
      logic pin;
      logic busy_res;
      logic accepted;
      logic train_done;
   } rsp_type;

endpackage

FILE: rtl/pwm_pulse_train_generator.sv
// ---------------------------------------------------------------------------
// PWM pulse train generator
// Tick driven PWM, pulse train and one-shot output generator.
// ---------------------------------------------------------------------------
// Reset is synchronous and active high. A request's response is registered
// on acceptance, in the skid stage if the output register still holds one.
// Throughput: one request per cycle while req_stall is low. Requests stall
// after reset and after every configuration write while the active phase
// length is recomputed: a product register forms period times duty, and a
// quotient register divides it by one hundred by reciprocal multiplication.
module pwm_pulse_train_generator #(
   parameter int TICK_WIDTH  = 24,
   parameter int PULSE_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  pwm_ptg_pkg::req_type                        req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output pwm_ptg_pkg::rsp_type                        rsp_data,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [pwm_ptg_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [pwm_ptg_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);
   import pwm_ptg_pkg::*;

`include "pwm_pulse_train_generator_assert.svh"

   // The product of period and duty, and the reciprocal that divides it by
   // one hundred. With the shift at the product width plus the bits of the
   // divisor, the truncated quotient is exact for every product.
   localparam int              PROD_W      = TICK_WIDTH + DUTY_WIDTH;
   localparam int              RECIP_SHIFT = PROD_W + $clog2(DUTY_DIVISOR);
   localparam int              RECIP_W     = PROD_W + 1;
   localparam int              MUL_W       = PROD_W + RECIP_W;
   localparam longint unsigned RECIP_VALUE =
      ((64'd1 << RECIP_SHIFT) + 64'(DUTY_DIVISOR - 1)) / 64'(DUTY_DIVISOR);
   localparam logic [1:0]      CALC_CYCLES = 2'd2;

   // -----------------------------------------------------------------------
   // Configuration registers. The port never pushes back.
   // -----------------------------------------------------------------------
   logic [TICK_WIDTH-1:0]  period_ff;
   logic [DUTY_WIDTH-1:0]  duty_ff;
   logic [PULSE_WIDTH-1:0] pulse_total_ff;
   logic [TICK_WIDTH-1:0]  one_shot_ff;
   logic                   invert_ff;
   logic                   csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= TICK_WIDTH'(1000);
         duty_ff        <= DUTY_WIDTH'(50);
         pulse_total_ff <= PULSE_WIDTH'(1);
         one_shot_ff    <= TICK_WIDTH'(1000);
         invert_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PERIOD:   period_ff      <= csr_wdata[TICK_WIDTH-1:0];
            REG_DUTY:     duty_ff        <= csr_wdata[DUTY_WIDTH-1:0];
            REG_PULSES:   pulse_total_ff <= csr_wdata[PULSE_WIDTH-1:0];
            REG_ONE_SHOT: one_shot_ff    <= csr_wdata[TICK_WIDTH-1:0];
            REG_INVERT:   invert_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // Active length calculation. The active phase is the period times the
   // duty divided by one hundred. The product is registered first, and the
   // quotient, taken from the product times the reciprocal, in the cycle after.
   // Both stages follow the registers continuously; a configuration write
   // holds requests off until the quotient reflects the new values.
   // -----------------------------------------------------------------------
   logic [1:0]            calc_cnt_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [MUL_W-1:0]      recip_prod;
   logic [TICK_WIDTH-1:0] act_ff;
   logic                  calc_busy;

   assign recip_prod = MUL_W'(prod_ff) * MUL_W'(RECIP_VALUE);
   assign calc_busy  = (calc_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         calc_cnt_ff <= CALC_CYCLES;
      end else if (calc_cnt_ff != '0) begin
         calc_cnt_ff <= calc_cnt_ff - 2'd1;
      end
   end

   // With the duty at most one hundred the quotient never exceeds the
   // period, so the low bits carry it whole.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(period_ff) * PROD_W'(duty_ff);
      act_ff  <= recip_prod[RECIP_SHIFT +: TICK_WIDTH];
   end

   // -----------------------------------------------------------------------
   // Generator state and its next value for the request being accepted.
   // -----------------------------------------------------------------------
   logic                   level_ff,       level_in;
   logic                   run_active_ff,  run_active_in;
   logic [1:0]             run_mode_ff,    run_mode_in;
   logic [TICK_WIDTH-1:0]  phase_left_ff,  phase_left_in;
   logic [PULSE_WIDTH-1:0] pulses_left_ff, pulses_left_in;
   logic [TICK_WIDTH-1:0]  active_len_ff,  active_len_in;
   logic [TICK_WIDTH-1:0]  idle_len_ff,    idle_len_in;
   logic                   accepted;
   logic                   train_done;
   logic                   req_accept;
   logic [TICK_WIDTH-1:0]  idle_raw;
   logic [TICK_WIDTH-1:0]  start_act_len;
   logic [PULSE_WIDTH-1:0] pulses_dec;
   logic                   start_ok;

   assign idle_raw      = period_ff - act_ff;
   assign start_act_len = (act_ff == '0) ? TICK_WIDTH'(1) : act_ff;
   assign pulses_dec    = pulses_left_ff - PULSE_WIDTH'(1);

   always_comb begin
      level_in       = level_ff;
      run_active_in  = run_active_ff;
      run_mode_in    = run_mode_ff;
      phase_left_in  = phase_left_ff;
      pulses_left_in = pulses_left_ff;
      active_len_in  = active_len_ff;
      idle_len_in    = idle_len_ff;
      accepted       = 1'b0;
      train_done     = 1'b0;
      start_ok       = 1'b0;

      case (req_data.kind)
         KIND_TICK: begin
            if (run_active_ff) begin
               if (phase_left_ff > TICK_WIDTH'(1)) begin
                  phase_left_in = phase_left_ff - TICK_WIDTH'(1);
               end else if (run_mode_ff == MODE_SHOT) begin
                  // A one-shot run flips its level once and ends.
                  level_in      = ~level_ff;
                  run_active_in = 1'b0;
                  phase_left_in = '0;
               end else if (level_ff ^ invert_ff) begin
                  // The active phase ends and the idle phase begins.
                  level_in      = invert_ff;
                  phase_left_in = idle_len_ff;
               end else if ((run_mode_ff == MODE_PULSE) && (pulses_dec == '0)) begin
                  // The last idle phase of a pulse train ends the run.
                  pulses_left_in = pulses_dec;
                  run_active_in  = 1'b0;
                  phase_left_in  = '0;
                  train_done     = 1'b1;
               end else begin
                  if (run_mode_ff == MODE_PULSE) begin
                     pulses_left_in = pulses_dec;
                  end
                  level_in      = ~invert_ff;
                  phase_left_in = active_len_ff;
               end
            end
         end
         KIND_START_PWM, KIND_START_PLS: begin
            start_ok = !run_active_ff && (duty_ff <= DUTY_WIDTH'(DUTY_MAX)) &&
                       !((req_data.kind == KIND_START_PLS) && (pulse_total_ff == '0));
            if (start_ok) begin
               active_len_in  = start_act_len;
               idle_len_in    = (idle_raw == '0) ? TICK_WIDTH'(1) : idle_raw;
               run_mode_in    = (req_data.kind == KIND_START_PLS) ? MODE_PULSE : MODE_CONT;
               run_active_in  = 1'b1;
               pulses_left_in = pulse_total_ff;
               level_in       = ~invert_ff;
               phase_left_in  = start_act_len;
               accepted       = 1'b1;
            end
         end
         KIND_ONE_SHOT: begin
            if (!run_active_ff) begin
               level_in      = req_data.level;
               run_active_in = 1'b1;
               run_mode_in   = MODE_SHOT;
               phase_left_in = (one_shot_ff == '0) ? TICK_WIDTH'(1) : one_shot_ff;
               accepted      = 1'b1;
            end
         end
         KIND_STOP: begin
            run_active_in = 1'b0;
            phase_left_in = '0;
            accepted      = 1'b1;
         end
         KIND_SET_LEVEL: begin
            if (!run_active_ff) begin
               level_in = req_data.level;
               accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state is reset; the stored phase lengths need no reset
   // because they are always written before a run reads them.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= 1'b0;
         run_active_ff  <= 1'b0;
         run_mode_ff    <= MODE_CONT;
         phase_left_ff  <= '0;
         pulses_left_ff <= '0;
      end else if (req_accept) begin
         level_ff       <= level_in;
         run_active_ff  <= run_active_in;
         run_mode_ff    <= run_mode_in;
         phase_left_ff  <= phase_left_in;
         pulses_left_ff <= pulses_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         active_len_ff <= active_len_in;
         idle_len_ff   <= idle_len_in;
      end
   end

   // -----------------------------------------------------------------------
   // Response register with a skid stage. A new request is taken while a
   // response waits, and the skid stage catches it if the consumer stalls.
   // The request side stalls only when the skid stage is full or while the
   // active length is being recomputed.
   // -----------------------------------------------------------------------
   logic    rsp_valid_ff;
   logic    skid_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type skid_data_ff;
   rsp_type rsp_new;
   logic    rsp_leave;

   assign req_stall  = skid_valid_ff | calc_busy;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_leave  = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_new.pin        = level_in ^ invert_ff;
      rsp_new.busy_res   = run_active_in;
      rsp_new.accepted   = accepted;
      rsp_new.train_done = train_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_leave) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (rsp_valid_ff && !rsp_leave) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_leave) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_leave) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_accept) begin
         if (rsp_valid_ff && !rsp_leave) begin
            skid_data_ff <= rsp_new;
         end else begin
            rsp_data_ff <= rsp_new;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -----------------------------------------------------------------------
   // Self checks.
   // -----------------------------------------------------------------------
   `PTG_ASSERT_SAME(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff,
                    "skid stage holds a response while the output register is empty")
   `PTG_ASSERT_SAME(a_run_has_phase, clock, reset, run_active_ff, phase_left_ff != '0,
                    "active run with no ticks left in its phase")
   `PTG_ASSERT_SAME(a_done_ends_run, clock, reset, rsp_valid_ff && rsp_data_ff.train_done,
                    !rsp_data_ff.busy_res && !rsp_data_ff.pin ^ invert_ff ||
                    !rsp_data_ff.busy_res && invert_ff,
                    "pulse train finished but the run is still marked busy")
   `PTG_ASSERT_NEXT(a_busy_refusal, clock, reset,
                    req_accept && run_active_ff && (req_data.kind == KIND_ONE_SHOT ||
                    req_data.kind == KIND_SET_LEVEL || req_data.kind == KIND_START_PWM ||
                    req_data.kind == KIND_START_PLS),
                    run_active_ff && $stable(phase_left_ff) && $stable(level_ff),
                    "command refused while busy changed the run state")

endmodule
